>>> rtl/mrg_pkg.sv
// Shared types and constants for the maze row generator.
// Holds the cell record, the cell command struct and the sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package mrg_pkg;

  localparam int unsigned MAX_COLUMNS = 32;
  localparam int unsigned LBL_W       = 6;
  localparam int unsigned COL_W       = $clog2(MAX_COLUMNS);
  localparam int unsigned CNT_W       = COL_W + 1;

  // register indexes on the configuration port
  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_ROW_COUNT    = 1'b1;

  // what one cell of the ring keeps for its column
  typedef struct packed {
    logic [LBL_W-1:0] label;
    logic             used;   // labelled and inside the active width
    logic             pend;   // not yet visited by the floor sweep
    logic             down;   // down request bit of this column
  } cell_t;

  typedef enum logic [2:0] {
    CELL_HOLD  = 3'd0,
    CELL_SHIFT = 3'd1,
    CELL_INIT  = 3'd2,
    CELL_PREP  = 3'd3,
    CELL_SETV  = 3'd4
  } cell_op_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_e         op;
    logic             relabel;
    logic [LBL_W-1:0] key;
    logic [LBL_W-1:0] to;
  } cell_ctl_t;

endpackage

>>> rtl/mrg_cell.sv
// One cell of the label ring: keeps one column's label and flags.
// Compares its label against the broadcast key and forwards a relabelled copy.
// Depends on mrg_pkg.
`timescale 1ns / 1ps

module mrg_cell import mrg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  cell_t     nb_i,
  input  logic      col_used_i,
  input  logic      aux_i,
  output cell_t     q_o,
  output cell_t     fwd_o,
  output logic      match_o
);

  cell_t cell_q, cell_d;

  // key hit, only for labelled cells
  assign match_o = cell_q.used && (cell_q.label == ctl_i.key);

  // copy handed to the left neighbor, merged set relabelled on the way
  always_comb begin
    fwd_o = cell_q;
    if (ctl_i.relabel && match_o) begin
      fwd_o.label = ctl_i.to;
    end
  end

  always_comb begin
    cell_d = cell_q;
    case (ctl_i.op)
      CELL_HOLD:  cell_d = cell_q;
      CELL_SHIFT: cell_d = nb_i;
      CELL_INIT: begin
        cell_d.used = cell_q.used & col_used_i;
        cell_d.down = aux_i;
        cell_d.pend = 1'b0;
      end
      CELL_PREP:  cell_d.pend = cell_q.used;
      CELL_SETV: begin
        cell_d.used = aux_i;
        cell_d.pend = 1'b0;
      end
      default:    cell_d = cell_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

>>> rtl/maze_row_generator_unit.sv
// Maze row generator: sequencer, configuration registers and the cell ring.
// Each row runs S_INIT, the fresh label pass (held while it probes for a free label),
//   the merge pass, S_PREP, the floor sweep, S_SETV and S_DONE; each pass rotates the
//   32-cell ring once. The final row of a maze skips S_PREP and the floor sweep.
// One row at a time: a new row is taken only in S_IDLE, once the previous row has entered
//   the output register. Reset clears all labels, the row counter and sets 32/32.
`timescale 1ns / 1ps

module maze_row_generator_unit import mrg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [30:0] join_random_i,
  input  logic [31:0] down_random_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [30:0] right_walls_o,
  output logic [31:0] floor_walls_o,
  output logic [15:0] row_number_o,
  output logic        final_row_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [CNT_W-1:0] MAX_COLS_C = CNT_W'(MAX_COLUMNS);
  localparam logic [CNT_W-1:0] MIN_COLS_C = CNT_W'(2);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_INIT  = 8'b0000_0010,
    S_FRESH = 8'b0000_0100,
    S_MERGE = 8'b0000_1000,
    S_PREP  = 8'b0001_0000,
    S_FLOOR = 8'b0010_0000,
    S_SETV  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [5:0]  col_cnt_q;
  logic [15:0] row_cnt_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= 6'(MAX_COLUMNS);
      row_cnt_q <= 16'd32;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COLUMN_COUNT) begin
        col_cnt_q <= pwdata[5:0];
      end else begin
        row_cnt_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_COLUMN_COUNT) begin
      prdata = {26'd0, col_cnt_q};
    end else begin
      prdata = {16'd0, row_cnt_q};
    end
  end

  // active width and row limit
  logic [CNT_W-1:0]       n_cols;
  logic [15:0]            rows;
  logic [MAX_COLUMNS-1:0] col_used;

  always_comb begin
    if (CNT_W'(col_cnt_q) < MIN_COLS_C) begin
      n_cols = MIN_COLS_C;
    end else if (CNT_W'(col_cnt_q) > MAX_COLS_C) begin
      n_cols = MAX_COLS_C;
    end else begin
      n_cols = CNT_W'(col_cnt_q);
    end
  end

  assign rows = (row_cnt_q == 16'd0) ? 16'd1 : row_cnt_q;

  for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_used
    assign col_used[g] = CNT_W'(g) < n_cols;
  end

  // per-row registers
  logic [15:0]            cur_row_q, cur_row_d;
  logic [15:0]            row_q;
  logic                   last_q, restart_q;
  logic [30:0]            join_q, join_d;
  logic [MAX_COLUMNS-1:0] down_q;
  logic [MAX_COLUMNS-1:0] right_q, right_d;
  logic [MAX_COLUMNS-1:0] floor_q, floor_d;
  logic [COL_W-1:0]       step_q, step_d;
  logic [LBL_W-1:0]       cand_q, cand_d;
  logic                   accept;
  logic                   restart_w;
  logic [15:0]            row_w;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign restart_w  = cur_row_q >= rows;
  assign row_w      = restart_w ? 16'd0 : cur_row_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      down_q    <= down_random_i;
      row_q     <= row_w;
      last_q    <= (row_w == (rows - 16'd1));
      restart_q <= restart_w;
    end
  end

  // cell ring
  cell_ctl_t              ctl;
  cell_t                  cell_q   [MAX_COLUMNS];
  cell_t                  cell_fwd [MAX_COLUMNS];
  cell_t                  tail_in;
  logic [MAX_COLUMNS-1:0] match;
  logic [MAX_COLUMNS-1:0] init_used;
  logic [MAX_COLUMNS-1:0] aux;

  assign init_used = col_used & {MAX_COLUMNS{~restart_q}};

  always_comb begin
    if (state_q == S_INIT) begin
      aux = down_q;
    end else if (last_q) begin
      aux = '0;
    end else begin
      aux = ~floor_q & col_used;
    end
  end

  for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_cell
    cell_t nb;
    if (g == MAX_COLUMNS - 1) begin : g_tail
      assign nb = tail_in;
    end else begin : g_mid
      assign nb = cell_fwd[g+1];
    end
    mrg_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .nb_i       (nb),
      .col_used_i (init_used[g]),
      .aux_i      (aux[g]),
      .q_o        (cell_q[g]),
      .fwd_o      (cell_fwd[g]),
      .match_o    (match[g])
    );
  end

  // head cell views
  cell_t                  head, nxt;
  logic                   head_in, pair_in;
  logic                   need_label, taken;
  logic                   do_join;
  logic [MAX_COLUMNS-1:0] down_vec, pend_vec;
  logic                   any_down, later, open;

  assign head       = cell_q[0];
  assign nxt        = cell_q[1];
  assign head_in    = {1'b0, step_q} < n_cols;
  assign pair_in    = ({1'b0, step_q} + CNT_W'(1)) < n_cols;
  assign need_label = head_in && !head.used;
  assign taken      = |match;
  assign do_join    = pair_in && (head.label != nxt.label) && (last_q || join_q[0]);

  for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_vec
    assign down_vec[g] = cell_q[g].down;
    assign pend_vec[g] = cell_q[g].pend;
  end

  assign any_down = |(match & down_vec);
  assign later    = |(match[MAX_COLUMNS-1:1] & pend_vec[MAX_COLUMNS-1:1]);
  assign open     = head.used && (head.down || (!any_down && !later));

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cand_d      = cand_q;
    join_d      = join_q;
    right_d     = right_q;
    floor_d     = floor_q;
    cur_row_d   = cur_row_q;
    ctl.op      = CELL_HOLD;
    ctl.relabel = 1'b0;
    ctl.key     = cand_q;
    ctl.to      = head.label;
    tail_in     = cell_fwd[0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          join_d  = join_random_i;
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        ctl.op  = CELL_INIT;
        step_d  = '0;
        cand_d  = '0;
        floor_d = '1;
        state_d = S_FRESH;
      end
      // hand out the smallest free label to every unlabelled column
      S_FRESH: begin
        ctl.key = cand_q;
        if (need_label && taken) begin
          cand_d = cand_q + LBL_W'(1);
        end else begin
          ctl.op = CELL_SHIFT;
          if (need_label) begin
            tail_in.label = cand_q;
            tail_in.used  = 1'b1;
          end
          step_d = step_q + COL_W'(1);
          if (step_q == COL_W'(MAX_COLUMNS - 1)) begin
            state_d = S_MERGE;
          end
        end
      end
      // join neighbor pairs left to right, relabel the whole right set
      S_MERGE: begin
        ctl.op      = CELL_SHIFT;
        ctl.key     = nxt.label;
        ctl.to      = head.label;
        ctl.relabel = do_join;
        right_d     = {~do_join, right_q[MAX_COLUMNS-1:1]};
        join_d      = {1'b0, join_q[30:1]};
        step_d      = step_q + COL_W'(1);
        if (step_q == COL_W'(MAX_COLUMNS - 1)) begin
          state_d = last_q ? S_SETV : S_PREP;
        end
      end
      S_PREP: begin
        ctl.op  = CELL_PREP;
        state_d = S_FLOOR;
      end
      // open floors per set, rightmost cell when the set chose none
      S_FLOOR: begin
        ctl.op       = CELL_SHIFT;
        ctl.key      = head.label;
        tail_in.pend = 1'b0;
        floor_d      = {~open, floor_q[MAX_COLUMNS-1:1]};
        step_d       = step_q + COL_W'(1);
        if (step_q == COL_W'(MAX_COLUMNS - 1)) begin
          state_d = S_SETV;
        end
      end
      S_SETV: begin
        ctl.op  = CELL_SETV;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          cur_row_d = last_q ? 16'd0 : (row_q + 16'd1);
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      step_q    <= '0;
      cand_q    <= '0;
      cur_row_q <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      cand_q    <= cand_d;
      cur_row_q <= cur_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    join_q  <= join_d;
    right_q <= right_d;
    floor_q <= floor_d;
  end

  // output register
  logic load_out;
  logic out_valid_q;

  assign load_out    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      right_walls_o <= right_q[30:0];
      floor_walls_o <= floor_q;
      row_number_o  <= row_q;
      final_row_o   <= last_q;
    end
  end

endmodule

>>> verif/tb.sv
// Testbench for maze_row_generator_unit: directed and random rows checked against
// a behavioral model of the row generator kept inside the bench.
// Depends on rtl/mrg_pkg.sv and rtl/maze_row_generator_unit.sv.
`timescale 1ns / 1ps

module tb import mrg_pkg::*; ();

  localparam int HOLD_CYCLES = 600;
  localparam int RANDOM_ROWS = 1450;

  // one generated maze row as seen on the result port
  typedef struct packed {
    logic [30:0] right;
    logic [31:0] floor;
    logic [15:0] num;
    logic        fin;
  } row_t;

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_SLUGGISH} ready_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [30:0] join_random_i = '0;
  logic [31:0] down_random_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [30:0] right_walls_o;
  logic [31:0] floor_walls_o;
  logic [15:0] row_number_o;
  logic        final_row_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  maze_row_generator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .join_random_i (join_random_i),
    .down_random_i (down_random_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .right_walls_o (right_walls_o),
    .floor_walls_o (floor_walls_o),
    .row_number_o  (row_number_o),
    .final_row_o   (final_row_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model state: labels, label flags, row counter and the two registers
  logic [LBL_W-1:0] maze_label [MAX_COLUMNS];
  logic [31:0]      maze_labelled;
  logic [15:0]      maze_row;
  logic [5:0]       cfg_cols;
  logic [15:0]      cfg_rows;

  row_t pending_rows[$];
  int   errors = 0;
  int   burst_left = 0;
  int   random_sent = 0;

  // receiver state: random stall patterns plus one long hold-off on request
  logic        hold_req = 1'b0;
  logic        hold_armed = 1'b0;
  int          hold_left = 0;
  int          mode_left = 0;
  ready_mode_e ready_mode = READY_ALWAYS;

  // smallest label held by no labelled cell in use
  function automatic logic [LBL_W-1:0] free_label(int n);
    logic taken;
    for (int c = 0; c < 64; c++) begin
      taken = 1'b0;
      for (int k = 0; k < n; k++)
        if (maze_labelled[k] && maze_label[k] == LBL_W'(c)) taken = 1'b1;
      if (!taken) return LBL_W'(c);
    end
    return '0;
  endfunction

  // advance the maze by one row and return what the block should emit
  function automatic row_t next_row(logic [30:0] jr, logic [31:0] dr);
    row_t             r;
    int               n;
    int               rows;
    int               rightmost;
    logic [31:0]      used;
    logic [31:0]      right;
    logic [31:0]      flr;
    logic             last_row;
    logic             any;
    logic [LBL_W-1:0] from;
    logic [LBL_W-1:0] to;
    logic [LBL_W-1:0] lab;
    n = (cfg_cols < 2) ? 2 : (cfg_cols > MAX_COLUMNS) ? MAX_COLUMNS : int'(cfg_cols);
    rows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
    used = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1);
    right = 32'h7FFF_FFFF;
    flr = 32'hFFFF_FFFF;
    if (int'(maze_row) >= rows) begin
      maze_row = '0;
      maze_labelled = '0;
    end
    r.num = maze_row;
    last_row = (int'(maze_row) == rows - 1);

    // fresh labels for unlabelled cells
    maze_labelled &= used;
    for (int j = 0; j < n; j++)
      if (!maze_labelled[j]) begin
        maze_label[j] = free_label(n);
        maze_labelled[j] = 1'b1;
      end

    // left-to-right joins, relabelling the whole right set
    for (int j = 0; j + 1 < n; j++)
      if (maze_label[j] != maze_label[j+1] && (last_row || jr[j])) begin
        from = maze_label[j+1];
        to = maze_label[j];
        right[j] = 1'b0;
        for (int k = 0; k < n; k++)
          if (maze_label[k] == from) maze_label[k] = to;
      end

    // floors: requested cells, else the rightmost cell of the set
    if (last_row) begin
      maze_labelled = '0;
      maze_row = '0;
    end else begin
      for (int j = 0; j < n; j++) begin
        lab = maze_label[j];
        any = 1'b0;
        rightmost = j;
        for (int k = 0; k < n; k++)
          if (maze_label[k] == lab) begin
            if (dr[k]) any = 1'b1;
            rightmost = k;
          end
        if (dr[j] || (!any && rightmost == j)) flr[j] = 1'b0;
      end
      maze_labelled = ~flr & used;
      maze_row = maze_row + 16'd1;
    end

    r.right = right[30:0];
    r.floor = flr;
    r.fin = last_row;
    return r;
  endfunction

  // random bit pattern: plain, sparse, dense or solid
  function automatic logic [31:0] pick_bits();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom & $urandom;
      4: return $urandom | $urandom;
      default: return $urandom;
    endcase
  endfunction

  // send one row request; bursts of items with random gaps between them
  task automatic send_row(input logic [30:0] jr, input logic [31:0] dr);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      case ($urandom_range(0, 7))
        0, 1: gap = 0;
        2: gap = $urandom_range(20, 150);
        default: gap = $urandom_range(1, 12);
      endcase
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    join_random_i <= jr;
    down_random_i <= dr;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    burst_left--;
    pending_rows.push_back(next_row(jr, dr));
  endtask

  // lower valid and wait for every expected row
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write followed by a read-back check
  task automatic set_reg(input logic idx, input logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == REG_COLUMN_COUNT) ? 32'h0000_003F : 32'h0000_FFFF;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    if (idx == REG_COLUMN_COUNT) cfg_cols = val[5:0];
    else cfg_rows = val[15:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    if ((prdata & mask) != (val & mask)) begin
      $error("readback reg %0d: expected %0h actual %0h", idx, val & mask, prdata & mask);
      errors++;
    end
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_shape(input logic [31:0] cols, input logic [31:0] rows);
    set_reg(REG_COLUMN_COUNT, cols);
    set_reg(REG_ROW_COUNT, rows);
  endtask

  // reset values: 32 columns, 32 rows; solid and alternating patterns
  task automatic test_reset_shape();
    send_row(31'h0000_0000, 32'h0000_0000);
    send_row(31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_row(31'h2AAA_AAAA, 32'h5555_5555);
    send_row(31'h5555_5555, 32'hAAAA_AAAA);
    drain();
  endtask

  // narrowest maze, wrapping past the final row into a new maze
  task automatic test_narrow();
    set_shape(2, 3);
    send_row(31'h7FFF_FFFE, 32'hFFFF_FFFC);
    send_row(31'h0000_0000, 32'h0000_0001);
    send_row(31'h0000_0000, 32'h0000_0000);
    send_row(31'h0000_0001, 32'h0000_0002);
    drain();
  endtask

  // column counts outside the legal range are clamped
  task automatic test_column_clamp();
    set_shape(0, 4);
    send_row(31'h7FFF_FFFF, 32'h0000_0000);
    drain();
    set_reg(REG_COLUMN_COUNT, 1);
    send_row(31'h0000_0000, 32'hFFFF_FFFF);
    drain();
    set_reg(REG_COLUMN_COUNT, 33);
    send_row(31'h1234_5678, 32'h9ABC_DEF0);
    drain();
    set_reg(REG_COLUMN_COUNT, 63);
    send_row(31'h0F0F_0F0F, 32'hF0F0_F0F0);
    drain();
  endtask

  // one-row mazes, and a zero row count acting as one
  task automatic test_single_row();
    set_shape(7, 1);
    send_row(31'h0000_0000, 32'hFFFF_FFFF);
    send_row(31'h7FFF_FFFF, 32'h0000_0000);
    drain();
    set_reg(REG_ROW_COUNT, 0);
    send_row(31'h0000_0015, 32'h0000_0000);
    send_row(31'h0000_0000, 32'h0000_0055);
    drain();
  endtask

  // row count lowered below the current row restarts the maze
  task automatic test_rows_lowered();
    set_shape(12, 8);
    send_row(31'h0000_0AAA, 32'h0000_0F0F);
    send_row(31'h0000_0555, 32'h0000_00F0);
    send_row(31'h0000_0123, 32'h0000_0800);
    drain();
    set_reg(REG_ROW_COUNT, 2);
    send_row(31'h0000_0000, 32'h0000_0000);
    send_row(31'h0000_0000, 32'h0000_0000);
    drain();
  endtask

  // widening mid-maze brings in unlabelled cells
  task automatic test_widen_midmaze();
    set_shape(5, 10);
    send_row(31'h0000_0005, 32'h0000_0011);
    send_row(31'h0000_0002, 32'h0000_000A);
    drain();
    set_reg(REG_COLUMN_COUNT, 20);
    send_row(31'h0005_5555, 32'h000A_0A0A);
    send_row(31'h0000_0000, 32'h0000_0000);
    drain();
  endtask

  // receiver holds off while rows keep coming, so the input stalls
  task automatic test_backpressure();
    logic [31:0] jr;
    logic [31:0] dr;
    set_shape(16, 6);
    hold_req <= 1'b1;
    repeat (8) begin
      jr = $urandom;
      dr = $urandom;
      send_row(jr[30:0], dr);
    end
    hold_req <= 1'b0;
    drain();
  endtask

  // random shapes and contents, phase by phase
  task automatic test_random_mazes();
    logic [31:0] cols;
    logic [31:0] rows;
    logic [31:0] jr;
    logic [31:0] dr;
    int          count;
    while (random_sent < RANDOM_ROWS) begin
      case ($urandom_range(0, 9))
        0: cols = 2;
        1: cols = 32;
        2: cols = $urandom_range(0, 1);
        3: cols = $urandom_range(33, 63);
        default: cols = $urandom_range(2, 32);
      endcase
      case ($urandom_range(0, 9))
        0: rows = 1;
        1: rows = 0;
        2: rows = 65535;
        3: rows = $urandom_range(20, 60);
        default: rows = $urandom_range(2, 10);
      endcase
      // upper bits of the write data are don't-care for the block
      if ($urandom_range(0, 3) == 0) cols |= {26'($urandom), 6'b0};
      if ($urandom_range(0, 3) == 0) rows |= {16'($urandom), 16'b0};
      set_shape(cols, rows);
      count = $urandom_range(10, 60);
      repeat (count) begin
        jr = pick_bits();
        dr = pick_bits();
        send_row(jr[30:0], dr);
        random_sent++;
      end
      drain();
    end
  endtask

  // result check against the oldest expected row
  always @(negedge clk_i) begin : check_row
    row_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rows.size() == 0) begin
        $error("row %0d produced with none expected", row_number_o);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        if (right_walls_o != want.right) begin
          $error("right_walls: expected %0h actual %0h", want.right, right_walls_o);
          errors++;
        end
        if (floor_walls_o != want.floor) begin
          $error("floor_walls: expected %0h actual %0h", want.floor, floor_walls_o);
          errors++;
        end
        if (row_number_o != want.num) begin
          $error("row_number: expected %0d actual %0d", want.num, row_number_o);
          errors++;
        end
        if (final_row_o != want.fin) begin
          $error("final_row: expected %0b actual %0b", want.fin, final_row_o);
          errors++;
        end
      end
    end
  end

  // receiver: random stall patterns plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && !hold_armed) hold_left = HOLD_CYCLES;
    hold_armed <= hold_req;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (ready_mode)
        READY_ALWAYS: out_ready_i <= 1'b1;
        READY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
        default:      out_ready_i <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // test sequence
  initial begin
    maze_labelled = '0;
    maze_row = '0;
    cfg_cols = 6'd32;
    cfg_rows = 16'd32;
    for (int k = 0; k < MAX_COLUMNS; k++) maze_label[k] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_shape();
    test_narrow();
    test_column_clamp();
    test_single_row();
    test_rows_lowered();
    test_widen_midmaze();
    test_backpressure();
    test_random_mazes();
    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

endmodule
